@@ design/sha256mh_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256mh_pkg
// Shared types, constants and sigma functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256mh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;  // index 0 is working word a

  // input operation codes
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // block geometry and padding
  localparam logic [5:0] BYTE_LAST  = 6'd63;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

@@ design/sha256_message_hasher_top.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// Streaming SHA-256 hasher: absorbs message bytes, emits the eight digest words.
// ----------------------------------------------------------------------------
// An absorb word is taken while idle; the 64th byte of a block then starts
// the compression, which holds the input off through 64 rounds in one
// shared round unit and then the chaining add. A finish word feeds the
// padding bytes through the same byte path, one per cycle (64 minus the
// pending bytes), compresses, and when 56 or more bytes were pending pads
// and compresses a second block. The eight
// digest words then leave one per accepted output cycle, word 0 first,
// and the hasher starts over from the initial hash values.
`default_nettype none

module sha256_message_hasher_top
  import sha256mh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] operation
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output      logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output      logic        m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e       state_q, state_d;
  logic [511:0] blk_q, blk_d;      // byte line, oldest byte / word on top
  hash_t        h_q, h_d;          // chaining words
  hash_t        v_q, v_d;          // working words
  logic [5:0]   cnt_q, cnt_d;      // bytes pending in block
  logic [5:0]   rnd_q, rnd_d;
  logic [63:0]  len_q, len_d;      // message bit count
  logic [2:0]   idx_q, idx_d;
  logic         fin_q, fin_d;      // finishing a message
  logic         mark_q, mark_d;    // 0x80 byte already placed
  logic         lenblk_q, lenblk_d;  // current pad block carries the length

  hash_t        v_next;
  word_t        w_next;
  logic [7:0]   pad_byte;
  logic         len_byte;

  // shared round unit
  sha256mh_round u_round (
    .v_i     (v_q),
    .w_i     (blk_q[511:480]),
    .k_i     (ROUND_K[rnd_q]),
    .w1_i    (blk_q[479:448]),
    .w9_i    (blk_q[223:192]),
    .w14_i   (blk_q[63:32]),
    .v_o     (v_next),
    .wnext_o (w_next)
  );

  // padding byte source
  always_comb begin
    len_byte = mark_q && lenblk_q && (cnt_q >= LEN_START);
    if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (len_byte) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    blk_d    = blk_q;
    h_d      = h_q;
    v_d      = v_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    len_d    = len_q;
    idx_d    = idx_q;
    fin_d    = fin_q;
    mark_d   = mark_q;
    lenblk_d = lenblk_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OP_FINISH) begin
            fin_d    = 1'b1;
            mark_d   = 1'b0;
            lenblk_d = (cnt_q < LEN_START);
            state_d  = ST_PAD;
          end else begin
            blk_d = {blk_q[503:0], s_axis_tdata};
            cnt_d = cnt_q + 6'd1;
            len_d = len_q + BYTE_BITS;
            if (cnt_q == BYTE_LAST) begin
              v_d     = h_q;
              rnd_d   = '0;
              state_d = ST_COMP;
            end
          end
        end
      end
      ST_PAD: begin
        blk_d  = {blk_q[503:0], pad_byte};
        cnt_d  = cnt_q + 6'd1;
        mark_d = 1'b1;
        if (len_byte) begin
          len_d = {len_q[55:0], 8'h00};
        end
        if (cnt_q == BYTE_LAST) begin
          v_d     = h_q;
          rnd_d   = '0;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        v_d   = v_next;
        blk_d = {blk_q[479:0], w_next};
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lenblk_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else begin
          lenblk_d = 1'b1;
          state_d  = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          if (idx_q == WORD_LAST) begin
            for (int i = 0; i < 8; i++) begin
              h_d[i] = INIT_HASH[i];
            end
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      blk_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= INIT_HASH[i];
      end
      v_q      <= '0;
      cnt_q    <= '0;
      rnd_q    <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenblk_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      blk_q    <= blk_d;
      h_q      <= h_d;
      v_q      <= v_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      fin_q    <= fin_d;
      mark_q   <= mark_d;
      lenblk_q <= lenblk_d;
    end
  end

  // port outputs
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = h_q[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == WORD_LAST);

endmodule

`default_nettype wire

@@ design/sha256mh_round.sv @@
// ----------------------------------------------------------------------------
// sha256mh_round
// One SHA-256 round plus the next message schedule word, reused every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256mh_round
  import sha256mh_pkg::*;
(
  input  hash_t v_i,        // working words a..h
  input  word_t w_i,        // schedule word of this round
  input  word_t k_i,        // round constant
  input  word_t w1_i,       // schedule word t+1
  input  word_t w9_i,       // schedule word t+9
  input  word_t w14_i,      // schedule word t+14
  output hash_t v_o,
  output word_t wnext_o     // schedule word t+16
);

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  // round function
  always_comb begin
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + big_sig1(v_i[4]) + ch + k_i + w_i;
    t2  = big_sig0(v_i[0]) + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

  // message schedule expansion
  assign wnext_o = small_sig1(w14_i) + w9_i + small_sig0(w1_i) + w_i;

endmodule

`default_nettype wire

@@ design/sha256mh_checker.sv @@
// ----------------------------------------------------------------------------
// sha256mh_checker
// Port-level assertions for the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256mh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled digest word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled digest word changed");

  // no input taken while the digest is being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during digest output");

  // the marked word is word seven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 3'd7)
    else $error("last word with wrong index");

  // digest words follow each other without a gap, in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest word sequence broken");

  // after the last word the hasher takes input again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after digest");

endmodule

bind sha256_message_hasher_top sha256mh_checker u_sha256mh_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming SHA-256 hasher: feeds messages byte by
// byte with random handshake gaps, keeps its own SHA-256 state to work out the
// eight digest words of every finish, and checks each word leaving the block.
// ----------------------------------------------------------------------------

module tb_top;
  import sha256mh_pkg::OP_ABSORB;
  import sha256mh_pkg::OP_FINISH;

  // one input word: operation plus message byte, optional drain before it
  typedef struct {
    logic       op;
    logic [7:0] data;
    bit         drain;
  } hash_item_t;

  // one digest word as it should leave the block
  typedef struct {
    logic [2:0]  idx;
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int unsigned RANDOM_ITEMS = 310;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser;   // [2:0] word_index
  logic        m_axis_tlast;   // last_word

  sha256_message_hasher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predicted hasher state
  logic [31:0] chain_q [8];
  logic [7:0]  blk_buf [64];
  int unsigned fill_cnt;
  logic [63:0] msg_bits;

  hash_item_t   msg_items_q [$];
  digest_word_t digest_q [$];

  int unsigned fail_cnt;
  int unsigned digests_seen;
  bit          in_accepted;
  bit          out_accepted;
  bit          in_burst;
  bit          out_burst;
  bit          long_hold_done;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned hold_cnt;

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // fold the 64-byte buffer into the chaining words
  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++)
      v[i] = chain_q[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++)
      chain_q[i] = chain_q[i] + v[i];
  endfunction

  function automatic void hash_restart();
    int i;
    for (i = 0; i < 8; i++)
      chain_q[i] = H_INIT[i];
    for (i = 0; i < 64; i++)
      blk_buf[i] = 8'h00;
    fill_cnt = 0;
    msg_bits = 64'd0;
  endfunction

  function automatic void hash_absorb(input logic [7:0] b);
    blk_buf[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt == 64) begin
      hash_block();
      msg_bits = msg_bits + 64'd512;
      fill_cnt = 0;
    end
  endfunction

  // pad, close the message and queue the eight digest words
  function automatic void hash_finish();
    logic [63:0] total;
    digest_word_t dw;
    int i;
    total = msg_bits + 64'(fill_cnt) * 64'd8;
    blk_buf[fill_cnt] = 8'h80;
    for (i = fill_cnt + 1; i < 64; i++)
      blk_buf[i] = 8'h00;
    // no room for the length: extra block
    if (fill_cnt >= 56) begin
      hash_block();
      for (i = 0; i < 56; i++)
        blk_buf[i] = 8'h00;
    end
    for (i = 0; i < 8; i++)
      blk_buf[63 - i] = total[8*i +: 8];
    hash_block();
    for (i = 0; i < 8; i++) begin
      dw.idx  = 3'(i);
      dw.word = chain_q[i];
      dw.last = (i == 7);
      digest_q.push_back(dw);
    end
    hash_restart();
  endfunction

  // wait length for one word, with stretches of back-to-back words
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 29) == 0)
      burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void push_item(input logic op, input logic [7:0] data, input bit drain);
    hash_item_t it;
    it.op    = op;
    it.data  = data;
    it.drain = drain;
    msg_items_q.push_back(it);
  endfunction

  function automatic void add_message(input int unsigned len, input bit drain);
    int unsigned i;
    for (i = 0; i < len; i++)
      push_item(OP_ABSORB, 8'($urandom), (i == 0) && drain);
    push_item(OP_FINISH, 8'($urandom), (len == 0) && drain);
  endfunction

  // sample accepted input words and update the prediction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == OP_FINISH)
        hash_finish();
      else
        hash_absorb(s_axis_tdata);
      in_accepted = 1'b1;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    logic valid_n;
    hash_item_t it;
    if (rst_ni && (!s_axis_tvalid || in_accepted)) begin
      if (s_axis_tvalid) begin
        in_accepted = 1'b0;
        in_gap = draw_wait(in_burst);
      end
      valid_n = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (msg_items_q.size() != 0 &&
                   !(msg_items_q[0].drain && digest_q.size() != 0)) begin
        it = msg_items_q.pop_front();
        s_axis_tdata <= it.data;
        s_axis_tuser <= it.op;
        valid_n = 1'b1;
      end
      s_axis_tvalid <= valid_n;
    end
  end

  // output ready, with one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    logic ready_n;
    if (rst_ni) begin
      if (out_accepted) begin
        out_accepted = 1'b0;
        out_stall = draw_wait(out_burst);
      end
      if (!long_hold_done && digests_seen == 6 && m_axis_tvalid) begin
        hold_cnt = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      ready_n = 1'b0;
      if (hold_cnt != 0)
        hold_cnt--;
      else if (out_stall != 0)
        out_stall--;
      else
        ready_n = 1'b1;
      m_axis_tready <= ready_n;
    end
  end

  // check each digest word against the oldest expectation
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_accepted = 1'b1;
      if (m_axis_tlast)
        digests_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected word index %0d data %08h last %0b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_cnt++;
      end else begin
        exp_w = digest_q.pop_front();
        if (m_axis_tuser !== exp_w.idx) begin
          $display("%0t: word_index expected %0d got %0d", $time, exp_w.idx, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata !== exp_w.word) begin
          $display("%0t: digest_word %0d expected %08h got %08h", $time, exp_w.idx,
                   exp_w.word, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $display("%0t: last_word %0d expected %0b got %0b", $time, exp_w.idx,
                   exp_w.last, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n_items;
    int unsigned len;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = OP_ABSORB;
    m_axis_tready  = 1'b0;
    rst_ni         = 1'b0;
    fail_cnt       = 0;
    digests_seen   = 0;
    in_accepted    = 1'b0;
    out_accepted   = 1'b0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;
    long_hold_done = 1'b0;
    in_gap         = 0;
    out_stall      = 0;
    hold_cnt       = 0;
    hash_restart();

    // empty message, "abc", byte extremes, back-to-back finish
    push_item(OP_FINISH, 8'hff, 1'b0);
    push_item(OP_ABSORB, 8'h61, 1'b0);
    push_item(OP_ABSORB, 8'h62, 1'b0);
    push_item(OP_ABSORB, 8'h63, 1'b0);
    push_item(OP_FINISH, 8'h00, 1'b0);
    push_item(OP_ABSORB, 8'hff, 1'b0);
    push_item(OP_ABSORB, 8'h00, 1'b0);
    push_item(OP_FINISH, 8'h5a, 1'b0);
    push_item(OP_FINISH, 8'ha5, 1'b0);

    // padding boundaries first, after the sender drains, then random messages
    add_message(56, 1'b1);
    add_message(63, 1'b0);
    add_message(55, 1'b0);
    n_items = 186;
    while (n_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        6, 7:    len = $urandom_range(52, 66);
        8:       len = $urandom_range(120, 130);
        9:       len = $urandom_range(0, 3);
        default: len = $urandom_range(0, 20);
      endcase
      add_message(len, 1'b0);
      n_items += len + 1;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (msg_items_q.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    while (digest_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && digest_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sha256mh_pkg.sv
design/sha256mh_round.sv
design/sha256_message_hasher_top.sv
design/sha256mh_checker.sv
tb/tb_top.sv
